### src/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, codes and helpers for the Playfair digram encryptor.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned SQ_SIDE     = 5;
  localparam int unsigned SQ_CELLS    = SQ_SIDE * SQ_SIDE;
  localparam int unsigned NUM_LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;
  typedef logic [4:0] cell_idx_t;

  localparam letter_t   LETTER_I     = 5'd8;
  localparam letter_t   LETTER_J     = 5'd9;
  localparam letter_t   LAST_LETTER  = 5'(NUM_LETTERS - 1);
  localparam letter_t   LETTER_LIMIT = 5'(NUM_LETTERS);
  localparam cell_idx_t SQUARE_FULL  = 5'(SQ_CELLS);
  localparam coord_t    LAST_COORD   = 3'(SQ_SIDE - 1);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_KEY     = 2'd1,
    OP_FINISH  = 2'd2,
    OP_ENCRYPT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // row in the upper bits, column in the lower bits
  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    logic    clear;
    logic    key_place;
    logic    fill_start;
    logic    fill_step;
    logic    set_complete;
    logic    pos_rd;
    logic    cell_rd;
    logic    load_out;
    logic    load_hold;
    logic    out_from_hold;
    logic    res_cipher;
    status_e res_st;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic dup;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

  function automatic letter_t fold_j(letter_t l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  function automatic coord_t wrap_inc(coord_t c);
    return (c == LAST_COORD) ? 3'd0 : c + 3'd1;
  endfunction

  // row * 5 + col, row and col both below 5
  function automatic cell_idx_t cell_idx(coord_t row, coord_t col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

### src/playfair_digram_encryptor_core.sv
// ----------------------------------------------------------------------------
// playfair_digram_encryptor_core
// Playfair 5x5 key square builder and digram encryptor, stream interface.
// ----------------------------------------------------------------------------
// Each input item carries an op: clear the square, add a key letter, finish
// the square, or encrypt a digram; each item gives exactly one result item
// with two cipher letters (zero unless an encrypt is done) and a status code.
// Letters are 0=A..25=Z and J is folded to I. Clear, key letter and any
// rejected op are done straight from the idle state; encrypt reads the
// position store, then the square store, each a registered read port;
// finish runs the fill sweep, which visits the 26 letters one per cycle
// through the single write port of the two stores. The output register
// parts the two sides: a result that cannot leave is parked in a hold
// register and the block waits there until the output is taken. No clearing
// pass runs after reset: the stores need none, as lookups only happen on a
// complete square.
// ----------------------------------------------------------------------------
module playfair_digram_encryptor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], letter_a[6:2], letter_b[11:7], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // cipher_a[4:0], cipher_b[9:5], status[11:10], zero
);
  import plf_pkg::*;

  op_e      op;
  letter_t  letter_a, letter_b, cipher_a, cipher_b;
  status_e  status;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // unpack input item
  assign op       = op_e'(s_axis_tdata[1:0]);
  assign letter_a = s_axis_tdata[6:2];
  assign letter_b = s_axis_tdata[11:7];

  plf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  plf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .letter_a_i  (letter_a),
    .letter_b_i  (letter_b),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cipher_a_o  (cipher_a),
    .cipher_b_o  (cipher_b),
    .status_o    (status)
  );

  // pack result item
  assign m_axis_tdata = {4'b0000, 2'(status), cipher_b, cipher_a};

endmodule

### src/plf_dp.sv
// ----------------------------------------------------------------------------
// plf_dp
// Datapath: key square and position stores, fill counters, digram lookup,
// result hold and output registers.
// ----------------------------------------------------------------------------
module plf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plf_pkg::op_e       op_i,
  input  plf_pkg::letter_t   letter_a_i,
  input  plf_pkg::letter_t   letter_b_i,
  input  plf_pkg::dp_cmd_t   cmd_i,
  output plf_pkg::dp_stat_t  stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output plf_pkg::letter_t   cipher_a_o,
  output plf_pkg::letter_t   cipher_b_o,
  output plf_pkg::status_e   status_o
);
  import plf_pkg::*;

  logic [NUM_LETTERS-1:0] placed_q, placed_d;
  cell_idx_t              fill_cnt_q;
  coord_t                 row_q, col_q;
  logic                   complete_q;
  letter_t                fill_let_q;
  logic                   out_valid_q;

  letter_t cell_mem [SQ_CELLS];
  pos_t    pos_mem  [NUM_LETTERS];

  pos_t    pos_a_q, pos_b_q;
  letter_t cell_a_q, cell_b_q;

  letter_t out_ca_q, out_cb_q, hold_ca_q, hold_cb_q;
  status_e out_st_q, hold_st_q;

  letter_t       la_f, lb_f, place_let, new_ca, new_cb;
  logic [31:0]   placed_ext;
  logic          la_ok, lb_ok, fill_cand, place_en, op_reject;
  cell_idx_t     idx_a, idx_b;

  assign la_f       = fold_j(letter_a_i);
  assign lb_f       = fold_j(letter_b_i);
  assign la_ok      = letter_a_i < LETTER_LIMIT;
  assign lb_ok      = letter_b_i < LETTER_LIMIT;
  assign placed_ext = {{(32 - NUM_LETTERS){1'b0}}, placed_q};

  always_comb begin
    case (op_i)
      OP_CLEAR:   op_reject = 1'b0;
      OP_KEY:     op_reject = complete_q || !la_ok;
      OP_FINISH:  op_reject = complete_q;
      OP_ENCRYPT: op_reject = !complete_q || !la_ok || !lb_ok;
      default:    op_reject = 1'b1;
    endcase
  end

  assign stat_o.reject    = op_reject;
  assign stat_o.dup       = placed_ext[la_f];
  assign stat_o.fill_last = (fill_let_q == LAST_LETTER);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // one letter placed per cycle, either a key letter or the next fill letter
  assign fill_cand = cmd_i.fill_step && (fill_let_q != LETTER_J) && !placed_ext[fill_let_q];
  assign place_en  = (cmd_i.key_place || fill_cand) && (fill_cnt_q < SQUARE_FULL);
  assign place_let = cmd_i.key_place ? la_f : fill_let_q;
  assign placed_d  = placed_q | (NUM_LETTERS'(1) << place_let);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q    <= '0;
      fill_cnt_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      complete_q  <= 1'b0;
      fill_let_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        placed_q   <= '0;
        fill_cnt_q <= '0;
        row_q      <= '0;
        col_q      <= '0;
        complete_q <= 1'b0;
      end else begin
        if (place_en) begin
          placed_q   <= placed_d;
          fill_cnt_q <= fill_cnt_q + 5'd1;
          if (col_q == LAST_COORD) begin
            col_q <= '0;
            row_q <= row_q + 3'd1;
          end else begin
            col_q <= col_q + 3'd1;
          end
        end
        if (cmd_i.set_complete) begin
          complete_q <= 1'b1;
        end
      end
      if (cmd_i.fill_start) begin
        fill_let_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_let_q <= fill_let_q + 5'd1;
      end
      if (cmd_i.load_out || cmd_i.out_from_hold) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stores: one write port, two registered read ports each
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      cell_mem[fill_cnt_q] <= place_let;
      pos_mem[place_let]   <= '{row: row_q, col: col_q};
    end
    if (cmd_i.pos_rd) begin
      pos_a_q <= pos_mem[la_f];
      pos_b_q <= pos_mem[lb_f];
    end
    if (cmd_i.cell_rd) begin
      cell_a_q <= cell_mem[idx_a];
      cell_b_q <= cell_mem[idx_b];
    end
  end

  // same row: shift right; same column: shift down; else swap columns
  always_comb begin
    if (pos_a_q.row == pos_b_q.row) begin
      idx_a = cell_idx(pos_a_q.row, wrap_inc(pos_a_q.col));
      idx_b = cell_idx(pos_b_q.row, wrap_inc(pos_b_q.col));
    end else if (pos_a_q.col == pos_b_q.col) begin
      idx_a = cell_idx(wrap_inc(pos_a_q.row), pos_a_q.col);
      idx_b = cell_idx(wrap_inc(pos_b_q.row), pos_b_q.col);
    end else begin
      idx_a = cell_idx(pos_a_q.row, pos_b_q.col);
      idx_b = cell_idx(pos_b_q.row, pos_a_q.col);
    end
  end

  assign new_ca = cmd_i.res_cipher ? cell_a_q : '0;
  assign new_cb = cmd_i.res_cipher ? cell_b_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ca_q <= new_ca;
      out_cb_q <= new_cb;
      out_st_q <= cmd_i.res_st;
    end else if (cmd_i.out_from_hold) begin
      out_ca_q <= hold_ca_q;
      out_cb_q <= hold_cb_q;
      out_st_q <= hold_st_q;
    end
    if (cmd_i.load_hold) begin
      hold_ca_q <= new_ca;
      hold_cb_q <= new_cb;
      hold_st_q <= cmd_i.res_st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cipher_a_o  = out_ca_q;
  assign cipher_b_o  = out_cb_q;
  assign status_o    = out_st_q;

`ifndef SYNTHESIS
  a_fill_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(placed_q) == 32'(fill_cnt_q))
    else $error("fill count out of step with placed flags");

  a_complete_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (fill_cnt_q == SQUARE_FULL))
    else $error("square marked complete but not full");

  a_no_j_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !placed_q[LETTER_J])
    else $error("J placed in square");

  a_lookup_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cell_rd |-> complete_q)
    else $error("cell lookup on incomplete square");
`endif

endmodule

### src/plf_ctrl.sv
// ----------------------------------------------------------------------------
// plf_ctrl
// Controller: op decode, fill sweep and encrypt sequencing, result routing.
// ----------------------------------------------------------------------------
module plf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plf_pkg::op_e      op_i,
  input  plf_pkg::dp_stat_t stat_i,
  output plf_pkg::dp_cmd_t  cmd_o
);
  import plf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_ENC1 = 5'b00100,
    S_ENC2 = 5'b01000,
    S_WAIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    logic fin;
    fin     = 1'b0;
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.reject) begin
            cmd_o.res_st = ST_REJECT;
            fin          = 1'b1;
          end else begin
            case (op_i)
              OP_CLEAR: begin
                cmd_o.clear = 1'b1;
                fin         = 1'b1;
              end
              OP_KEY: begin
                if (stat_i.dup) begin
                  cmd_o.res_st = ST_DUP;
                end else begin
                  cmd_o.key_place = 1'b1;
                end
                fin = 1'b1;
              end
              OP_FINISH: begin
                cmd_o.fill_start = 1'b1;
                state_d          = S_FILL;
              end
              OP_ENCRYPT: begin
                cmd_o.pos_rd = 1'b1;
                state_d      = S_ENC1;
              end
              default: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.set_complete = 1'b1;
          fin                = 1'b1;
        end
      end
      S_ENC1: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = S_ENC2;
      end
      S_ENC2: begin
        cmd_o.res_cipher = 1'b1;
        fin              = 1'b1;
      end
      S_WAIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_from_hold = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // result goes straight out if the output register is free, else parks
    if (fin) begin
      if (stat_i.out_free) begin
        cmd_o.load_out = 1'b1;
        state_d        = S_IDLE;
      end else begin
        cmd_o.load_hold = 1'b1;
        state_d         = S_WAIT;
      end
    end
  end

endmodule
